/* hdl/ptta_pkg.sv */
`default_nettype none

package ptta_pkg;

  localparam logic [1:0] MODE_PASS  = 2'd0;
  localparam logic [1:0] MODE_STRIP = 2'd1;
  localparam logic [1:0] MODE_QUAD  = 2'd2;

  localparam int unsigned HeldDepth  = 3;
  localparam int unsigned HeldIdxW   = $clog2(HeldDepth);
  localparam int unsigned StripKeep  = 2;
  localparam int unsigned QuadSize   = 4;
  localparam int unsigned JobSlots   = 4;
  localparam int unsigned SlotIdxW   = $clog2(JobSlots);
  localparam int unsigned MaxRun     = 6;
  localparam int unsigned StepW      = $clog2(MaxRun);
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] u;
    logic [31:0] v;
    logic [31:0] rgba;
  } vertex_t;

  typedef struct packed {
    logic        start_of_list;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] tex_u;
    logic [31:0] tex_v;
    logic [31:0] rgba;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_u;
    logic [31:0] out_v;
    logic [31:0] out_rgba;
    logic        last_of_run;
  } out_item_t;

  typedef enum logic [1:0] {
    JOB_PASS,
    JOB_TRI,
    JOB_QUAD
  } job_kind_e;

  typedef struct packed {
    job_kind_e                  kind;
    vertex_t [JobSlots-1:0]     vtx;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_push_t;

  function automatic logic [StepW-1:0] job_len(job_kind_e kind);
    logic [StepW-1:0] len;
    unique case (kind)
      JOB_PASS: len = StepW'(1);
      JOB_TRI:  len = StepW'(3);
      JOB_QUAD: len = StepW'(MaxRun);
      default:  len = StepW'(1);
    endcase
    return len;
  endfunction

  // quad run emits a, b, c, c, d, b
  function automatic logic [SlotIdxW-1:0] job_slot(job_kind_e kind, logic [StepW-1:0] step);
    logic [SlotIdxW-1:0] slot;
    slot = step[SlotIdxW-1:0];
    if (kind == JOB_QUAD) begin
      case (step)
        StepW'(0): slot = SlotIdxW'(0);
        StepW'(1): slot = SlotIdxW'(1);
        StepW'(2): slot = SlotIdxW'(2);
        StepW'(3): slot = SlotIdxW'(2);
        StepW'(4): slot = SlotIdxW'(3);
        default:   slot = SlotIdxW'(1);
      endcase
    end
    return slot;
  endfunction

endpackage

`default_nettype wire

/* hdl/primitive_to_triangle_assembler_unit.sv */
`default_nettype none

// Converts a vertex stream into a triangle list: pass-through, triangle strip
// (three vertices per input from the third on, winding kept) or quads (six
// vertices on every fourth input). The front takes one vertex per cycle unless
// the queue is full or a mode write is pending, into a two-entry job queue; the
// back drains one vertex per cycle, unless stalled, through a registered output,
// so strip and quad input rates are set by the single output port. start_of_list
// or a mode write restarts the list; a mode write holds input off for its cycle.
module primitive_to_triangle_assembler_unit (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire  [1:0]          cfg_source_mode_i,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  ptta_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output ptta_pkg::out_item_t out_item_o
);

  ptta_pkg::job_push_t push;
  ptta_pkg::job_t      head_job;
  logic                q_full, q_valid, q_pop, in_accept;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !q_full && !cfg_valid_i;
  assign in_accept   = in_valid_i && in_ready_o;

  ptta_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_source_mode_i (cfg_source_mode_i),
    .in_accept_i       (in_accept),
    .in_item_i         (in_item_i),
    .push_o            (push)
  );

  ptta_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .job_o   (head_job)
  );

  ptta_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (head_job),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

/* hdl/ptta_front.sv */
`default_nettype none

module ptta_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_valid_i,
  input  wire  [1:0]          cfg_source_mode_i,
  input  wire                 in_accept_i,
  input  ptta_pkg::in_item_t  in_item_i,
  output ptta_pkg::job_push_t push_o
);

  logic [1:0]                      mode_q, mode_d;
  logic [1:0]                      phase_q, phase_d;
  logic [1:0]                      ready_q, ready_d;
  logic                            parity_q, parity_d;
  ptta_pkg::vertex_t               held_q [ptta_pkg::HeldDepth];
  ptta_pkg::vertex_t               held_d [ptta_pkg::HeldDepth];
  ptta_pkg::vertex_t               cur;
  logic [1:0]                      phase_eff, ready_eff;
  logic                            parity_eff;

  assign cur.x    = in_item_i.pos_x;
  assign cur.y    = in_item_i.pos_y;
  assign cur.u    = in_item_i.tex_u;
  assign cur.v    = in_item_i.tex_v;
  assign cur.rgba = in_item_i.rgba;

  assign phase_eff  = in_item_i.start_of_list ? 2'd0 : phase_q;
  assign ready_eff  = in_item_i.start_of_list ? 2'd0 : ready_q;
  assign parity_eff = in_item_i.start_of_list ? 1'b0 : parity_q;

  always_comb begin
    mode_d      = mode_q;
    phase_d     = phase_q;
    ready_d     = ready_q;
    parity_d    = parity_q;
    held_d      = held_q;
    push_o      = '0;
    push_o.job.kind = ptta_pkg::JOB_PASS;
    if (cfg_valid_i) begin
      mode_d   = cfg_source_mode_i;
      phase_d  = 2'd0;
      ready_d  = 2'd0;
      parity_d = 1'b0;
    end else if (in_accept_i) begin
      phase_d  = phase_eff;
      ready_d  = ready_eff;
      parity_d = parity_eff;
      case (mode_q)
        ptta_pkg::MODE_STRIP: begin
          if (ready_eff < 2'(ptta_pkg::StripKeep)) begin
            held_d[ready_eff[ptta_pkg::HeldIdxW-1:0]] = cur;
            ready_d = ready_eff + 2'd1;
          end else begin
            push_o.valid      = 1'b1;
            push_o.job.kind   = ptta_pkg::JOB_TRI;
            push_o.job.vtx[0] = held_q[0];
            push_o.job.vtx[1] = parity_eff ? held_q[1] : cur;
            push_o.job.vtx[2] = parity_eff ? cur : held_q[1];
            held_d[0] = held_q[1];
            held_d[1] = cur;
            parity_d  = ~parity_eff;
          end
        end
        ptta_pkg::MODE_QUAD: begin
          if (phase_eff < 2'(ptta_pkg::QuadSize - 1)) begin
            held_d[phase_eff[ptta_pkg::HeldIdxW-1:0]] = cur;
            phase_d = phase_eff + 2'd1;
          end else begin
            push_o.valid      = 1'b1;
            push_o.job.kind   = ptta_pkg::JOB_QUAD;
            push_o.job.vtx[0] = held_q[0];
            push_o.job.vtx[1] = held_q[1];
            push_o.job.vtx[2] = held_q[2];
            push_o.job.vtx[3] = cur;
            phase_d = 2'd0;
          end
        end
        default: begin
          push_o.valid      = 1'b1;
          push_o.job.kind   = ptta_pkg::JOB_PASS;
          push_o.job.vtx[0] = cur;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ptta_pkg::MODE_PASS;
      phase_q  <= 2'd0;
      ready_q  <= 2'd0;
      parity_q <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      phase_q  <= phase_d;
      ready_q  <= ready_d;
      parity_q <= parity_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

endmodule

`default_nettype wire

/* hdl/ptta_queue.sv */
`default_nettype none

module ptta_queue (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  ptta_pkg::job_push_t push_i,
  input  wire                 pop_i,
  output logic                full_o,
  output logic                valid_o,
  output ptta_pkg::job_t      job_o
);

  ptta_pkg::job_t                   mem_q [ptta_pkg::QueueDepth];
  logic [ptta_pkg::QueuePtrW-1:0]   wr_q, rd_q;
  logic [ptta_pkg::QueueCntW-1:0]   cnt_q;
  logic                             do_pop;

  assign full_o  = (cnt_q == ptta_pkg::QueueCntW'(ptta_pkg::QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_q] <= push_i.job;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i.valid) begin
        wr_q <= wr_q + ptta_pkg::QueuePtrW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + ptta_pkg::QueuePtrW'(1);
      end
      cnt_q <= cnt_q + ptta_pkg::QueueCntW'(push_i.valid) - ptta_pkg::QueueCntW'(do_pop);
    end
  end

endmodule

`default_nettype wire

/* hdl/ptta_back.sv */
`default_nettype none

module ptta_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 job_valid_i,
  input  ptta_pkg::job_t      job_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output ptta_pkg::out_item_t out_item_o
);

  logic [ptta_pkg::StepW-1:0]    step_q, step_d;
  logic                          out_valid_q, out_valid_d;
  ptta_pkg::out_item_t           out_q, out_d;
  logic                          advance, is_last;
  logic [ptta_pkg::StepW-1:0]    run_len;
  ptta_pkg::vertex_t             sel;

  assign advance = !out_valid_q || out_ready_i;
  assign run_len = ptta_pkg::job_len(job_i.kind);
  assign is_last = (step_q == run_len - ptta_pkg::StepW'(1));
  assign sel     = job_i.vtx[ptta_pkg::job_slot(job_i.kind, step_q)];
  assign pop_o   = advance && job_valid_i && is_last;

  always_comb begin
    step_d      = step_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (advance) begin
      out_valid_d = job_valid_i;
      if (job_valid_i) begin
        out_d.out_x       = sel.x;
        out_d.out_y       = sel.y;
        out_d.out_u       = sel.u;
        out_d.out_v       = sel.v;
        out_d.out_rgba    = sel.rgba;
        out_d.last_of_run = is_last;
        step_d = is_last ? '0 : step_q + ptta_pkg::StepW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_idle_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !job_valid_i |-> step_q == '0)
    else $error("step counter moved without a job");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_i |-> step_q < run_len)
    else $error("step beyond run length");

  a_pop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_valid_q && out_q.last_of_run)
    else $error("job retired without last vertex");

endmodule

`default_nettype wire
